// File: hdl/i2cb_pkg.sv
// shared types and constants for the i2c master bit engine
`timescale 1ns / 1ps
`default_nettype none
package i2cb_pkg;

  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_START   = 4'd1,
    OP_RESTART = 4'd2,
    OP_STOP    = 4'd3,
    OP_WRITE   = 4'd4,
    OP_READ    = 4'd5,
    OP_CHK_ACK = 4'd6,
    OP_ACK     = 4'd7,
    OP_NACK    = 4'd8
  } op_t;

  localparam int unsigned CFG_W = 16;
  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_READ_LEAD   = 1'b1;

  localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd100;
  localparam logic [CFG_W-1:0] READ_LEAD_RST   = 16'd500;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data_byte;
    logic       sda_level;
  } in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       ack_error;
    logic       refused;
  } out_t;

  // classified tick as it waits in the queue
  typedef struct packed {
    logic [3:0] op;
    logic       is_cmd;
    logic       nonzero;
    logic [7:0] data_byte;
    logic       sda_level;
  } tick_t;

endpackage
`default_nettype wire

// File: hdl/i2c_master_bit_engine.sv
// I2C master pin sequencer: each input item is one tick, each tick gives one result item
//
// Usage: every tick enters on the in channel (valid/ready) with an optional command
// (start, restart, stop, write, read, check ack, ack, nack), a write byte and the
// sampled SDA level. Each tick yields one result item on the out channel holding
// the SCL/SDA release levels, busy, done, the last byte read, the ack error and a
// refused flag for a command that came in while another was running.
// Configuration: cfg_wen/cfg_idx/cfg_wdata write half_period_ticks (index 0) and
// read_lead_ticks (index 1); the user must write them only while the block is idle, the block does not enforce it.
// Throughput: one tick per clock cycle while out_ready is high; the sequencer advances one tick per cycle.
// Path: an accepted tick is written into the queue, then the sequencer registers its result
// in the output register; a four-entry queue separates the input side from the sequencer.
// Stall: with out_ready low the finished result holds in the output register, the
// queue fills, and in_ready drops once it is full; nothing is dropped.
// Reset (rst, synchronous): pins released, no command, read byte and ack error
// cleared, registers back to 100 and 500 ticks; the queue and output are emptied.
`timescale 1ns / 1ps
`default_nettype none
module i2c_master_bit_engine import i2cb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic             cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_item
);

  logic  q_full, q_push, q_pop, q_not_empty;
  tick_t q_in, q_out;

  i2cb_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  i2cb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  i2cb_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

// File: hdl/i2cb_front.sv
// input side: accepts ticks and classifies their command codes
`timescale 1ns / 1ps
`default_nettype none
module i2cb_front import i2cb_pkg::*; (
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire in_t   in_item,
  input  wire logic  q_full,
  output logic       q_push,
  output tick_t      q_data
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.op        = in_item.op;
    q_data.is_cmd    = (in_item.op inside {[OP_START:OP_NACK]});
    q_data.nonzero   = (in_item.op != OP_NONE);
    q_data.data_byte = in_item.data_byte;
    q_data.sda_level = in_item.sda_level;
  end

endmodule
`default_nettype wire

// File: hdl/i2cb_queue.sv
// short queue of classified ticks between front and sequencer
`timescale 1ns / 1ps
`default_nettype none
module i2cb_queue import i2cb_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire tick_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output tick_t      pop_data
);

  tick_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full      = (count == (Q_AW+1)'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2cb_seq.sv
// back end: pin sequencer state, config registers and output register
`timescale 1ns / 1ps
`default_nettype none
module i2cb_seq import i2cb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wen,
  input  wire logic             cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             q_not_empty,
  input  wire tick_t            q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_item
);

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  logic [CFG_W-1:0] half_period;
  logic [CFG_W-1:0] read_lead;

  logic             scl, sda;
  logic [3:0]       cmd;
  logic [1:0]       phase;
  logic [3:0]       bit_idx;
  logic [7:0]       shift;
  logic [CFG_W-1:0] wcnt;
  logic             ack;
  logic [7:0]       last_read;

  logic             scl_next, sda_next;
  logic [3:0]       cmd_next;
  logic [1:0]       phase_next;
  logic [3:0]       bit_idx_next;
  logic [7:0]       shift_next;
  logic [CFG_W-1:0] wcnt_next;
  logic             ack_next;
  logic [7:0]       last_read_next;
  out_t             res;

  // pin levels {scl, sda} on entry to a segment
  function automatic logic [1:0] seg_pins(input logic [3:0] c, input logic [1:0] ph,
                                          input logic msb, input logic [1:0] cur);
    logic [1:0] p;
    p = cur;
    case (op_t'(c))
      OP_START: begin
        if (ph == PH_A) p[1] = 1'b1;
        else p[0] = 1'b0;
      end
      OP_RESTART: begin
        if (ph == PH_A) p = 2'b01;
        else if (ph == PH_B) p[1] = 1'b1;
        else p[0] = 1'b0;
      end
      OP_STOP: begin
        if (ph == PH_A) p = 2'b00;
        else if (ph == PH_B) p[1] = 1'b1;
        else p[0] = 1'b1;
      end
      default: begin
        if (ph == PH_A) begin
          p[1] = 1'b0;
          if (op_t'(c) == OP_WRITE) p[0] = msb;
          else if (op_t'(c) == OP_ACK) p[0] = 1'b0;
          else p[0] = 1'b1;
        end else begin
          p[1] = 1'b1;
        end
      end
    endcase
    return p;
  endfunction

  assign q_pop = q_not_empty && (!out_valid || out_ready);

  always_comb begin
    logic [CFG_W-1:0] seg_len;
    logic [1:0]       pins;
    logic             scl_out, sda_out;
    logic             finish;
    logic [3:0]       nbits;
    seg_len        = (half_period == '0) ? CFG_W'(1) : half_period;
    pins           = 2'b00;
    scl_next       = scl;
    sda_next       = sda;
    cmd_next       = cmd;
    phase_next     = phase;
    bit_idx_next   = bit_idx;
    shift_next     = shift;
    wcnt_next      = wcnt;
    ack_next       = ack;
    last_read_next = last_read;
    finish         = 1'b0;
    nbits          = 4'd1;
    res            = '0;

    // command pickup
    if (cmd == OP_NONE) begin
      if (q_data.is_cmd) begin
        cmd_next     = q_data.op;
        bit_idx_next = '0;
        shift_next   = (q_data.op == OP_WRITE) ? q_data.data_byte : 8'h00;
        if (q_data.op == OP_READ && read_lead != '0) begin
          phase_next = PH_C;
          wcnt_next  = read_lead;
        end else begin
          phase_next = PH_A;
          wcnt_next  = seg_len;
          pins       = seg_pins(q_data.op, PH_A, shift_next[7], {scl, sda});
          scl_next   = pins[1];
          sda_next   = pins[0];
        end
      end
    end else begin
      res.refused = q_data.nonzero;
    end

    scl_out = scl_next;
    sda_out = sda_next;

    // segment countdown and advance
    if (cmd_next != OP_NONE) begin
      if (wcnt_next != '0) wcnt_next = wcnt_next - 1'b1;
      if (wcnt_next == '0) begin
        case (op_t'(cmd_next))
          OP_START: begin
            if (phase_next == PH_A) phase_next = PH_B;
            else finish = 1'b1;
          end
          OP_RESTART, OP_STOP: begin
            if (phase_next inside {PH_A, PH_B}) phase_next = phase_next + 1'b1;
            else finish = 1'b1;
          end
          default: begin
            if (phase_next == PH_C) begin
              phase_next = PH_A;
            end else if (phase_next == PH_A) begin
              phase_next = PH_B;
            end else begin
              // end of an scl high segment: sample sda
              nbits = (cmd_next inside {OP_WRITE, OP_READ}) ? 4'd8 : 4'd1;
              if (cmd_next == OP_WRITE) shift_next = {shift_next[6:0], 1'b0};
              if (cmd_next == OP_READ)  shift_next = {shift_next[6:0], q_data.sda_level};
              if (cmd_next == OP_CHK_ACK) ack_next = q_data.sda_level;
              bit_idx_next = bit_idx_next + 1'b1;
              if (bit_idx_next < nbits) begin
                phase_next = PH_A;
              end else begin
                finish = 1'b1;
                if (cmd_next == OP_READ) last_read_next = shift_next;
              end
            end
          end
        endcase
        if (finish) begin
          cmd_next     = OP_NONE;
          phase_next   = PH_A;
          bit_idx_next = '0;
          wcnt_next    = '0;
        end else begin
          wcnt_next = seg_len;
          pins      = seg_pins(cmd_next, phase_next, shift_next[7], {scl_next, sda_next});
          scl_next  = pins[1];
          sda_next  = pins[0];
        end
      end
    end

    res.scl_release = scl_out;
    res.sda_release = sda_out;
    res.busy_res    = (cmd_next != OP_NONE);
    res.done_res    = finish;
    res.read_value  = last_read_next;
    res.ack_error   = ack_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RST;
      read_lead   <= READ_LEAD_RST;
    end else if (cfg_wen) begin
      case (cfg_idx)
        CFG_HALF_PERIOD: half_period <= cfg_wdata;
        CFG_READ_LEAD:   read_lead   <= cfg_wdata;
        default:         half_period <= half_period;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scl       <= 1'b1;
      sda       <= 1'b1;
      cmd       <= OP_NONE;
      phase     <= PH_A;
      bit_idx   <= '0;
      shift     <= '0;
      wcnt      <= '0;
      ack       <= 1'b0;
      last_read <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        scl       <= scl_next;
        sda       <= sda_next;
        cmd       <= cmd_next;
        phase     <= phase_next;
        bit_idx   <= bit_idx_next;
        shift     <= shift_next;
        wcnt      <= wcnt_next;
        ack       <= ack_next;
        last_read <= last_read_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_item <= res;
  end

  // a held result is never overwritten
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !q_pop)
    else $error("sequencer advanced while a result was stalled");

  // done ends the command in the same item
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.done_res) |-> !out_item.busy_res)
    else $error("done reported with command still busy");

  // idle sequencer holds its counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_NONE) |-> (wcnt == '0 && bit_idx == '0 && phase == PH_A))
    else $error("idle sequencer with stale counters");

  // refusal only while a command was running
  a_refuse_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop && res.refused |-> (cmd != OP_NONE))
    else $error("refused flagged while idle");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the i2c master bit engine: directed table, then random ticks
`timescale 1ns / 1ps
module tb_top;
  import i2cb_pkg::*;

  typedef enum logic {
    ROW_TICK,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic             cfg_sel;
    logic [CFG_W-1:0] cfg_val;
    in_t              tick;
    logic             drain;
    logic             typed;
    out_t             want;
  } stim_row_t;

  localparam out_t IDLE_AFTER_RESET = '{scl_release: 1'b1, sda_release: 1'b1,
                                        busy_res: 1'b0, done_res: 1'b0,
                                        read_value: 8'h00, ack_error: 1'b0,
                                        refused: 1'b0};
  localparam int IDLE_PCT      = 28;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 56;
  localparam int SHOW_LIMIT    = 10;

  logic             clk;
  logic             rst;
  logic             cfg_wen;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  in_t              in_item;
  logic             out_valid;
  logic             out_ready;
  out_t             out_item;

  i2c_master_bit_engine dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // sequencer mirror
  logic [CFG_W-1:0] half_ticks;
  logic [CFG_W-1:0] lead_ticks;
  logic             scl_q;
  logic             sda_q;
  op_t              cmd_q;
  logic [1:0]       phase_q;
  logic [3:0]       bit_q;
  logic [7:0]       shift_q;
  logic [15:0]      wait_q;
  logic             ack_q;
  logic [7:0]       read_q;

  out_t      expected_pins[$];
  stim_row_t stim_table[$];
  int        mismatch_count = 0;
  bit        idling = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("i2c_master_bit_engine test failed");
    $finish;
  end

  function automatic in_t make_tick(logic [3:0] op, logic [7:0] data, logic sda);
    in_t t;
    t.op = op;
    t.data_byte = data;
    t.sda_level = sda;
    return t;
  endfunction

  function automatic stim_row_t tick_row(logic [3:0] op, logic [7:0] data, logic sda,
                                         logic drain);
    stim_row_t r;
    r = '0;
    r.kind = ROW_TICK;
    r.tick = make_tick(op, data, sda);
    r.drain = drain;
    return r;
  endfunction

  // tick on an idle engine right after reset: result is known without prediction
  function automatic stim_row_t idle_row(logic [3:0] op, logic sda);
    stim_row_t r;
    r = tick_row(op, 8'h5A, sda, 1'b0);
    r.typed = 1'b1;
    r.want = IDLE_AFTER_RESET;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic sel, logic [CFG_W-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  task automatic enter_segment(input logic [1:0] ph);
    phase_q = ph;
    wait_q = (half_ticks == '0) ? 16'd1 : half_ticks;
    case (cmd_q)
      OP_START: begin
        if (ph == 2'd0) scl_q = 1'b1;
        else sda_q = 1'b0;
      end
      OP_RESTART: begin
        if (ph == 2'd0) begin
          scl_q = 1'b0;
          sda_q = 1'b1;
        end else if (ph == 2'd1) scl_q = 1'b1;
        else sda_q = 1'b0;
      end
      OP_STOP: begin
        if (ph == 2'd0) begin
          scl_q = 1'b0;
          sda_q = 1'b0;
        end else if (ph == 2'd1) scl_q = 1'b1;
        else sda_q = 1'b1;
      end
      default: begin
        if (ph == 2'd0) begin
          scl_q = 1'b0;
          if (cmd_q == OP_WRITE) sda_q = shift_q[7];
          else if (cmd_q == OP_ACK) sda_q = 1'b0;
          else sda_q = 1'b1;
        end else begin
          scl_q = 1'b1;
        end
      end
    endcase
  endtask

  task automatic close_segment(input logic sda_in, output logic finished);
    logic       bit_cmd;
    logic [3:0] nbits;
    finished = 1'b0;
    bit_cmd = !(cmd_q == OP_START || cmd_q == OP_RESTART || cmd_q == OP_STOP);
    nbits = (cmd_q == OP_WRITE || cmd_q == OP_READ) ? 4'd8 : 4'd1;
    if (cmd_q == OP_START && phase_q == 2'd0) begin
      enter_segment(2'd1);
    end else if ((cmd_q == OP_RESTART || cmd_q == OP_STOP) && phase_q < 2'd2) begin
      enter_segment(phase_q + 2'd1);
    end else if (bit_cmd && phase_q == 2'd2) begin
      // read lead time over
      enter_segment(2'd0);
    end else if (bit_cmd && phase_q == 2'd0) begin
      enter_segment(2'd1);
    end else begin
      if (bit_cmd) begin
        if (cmd_q == OP_WRITE) shift_q = {shift_q[6:0], 1'b0};
        if (cmd_q == OP_READ) shift_q = {shift_q[6:0], sda_in};
        if (cmd_q == OP_CHK_ACK) ack_q = sda_in;
        bit_q = bit_q + 4'd1;
      end
      if (bit_cmd && bit_q < nbits) begin
        enter_segment(2'd0);
      end else begin
        if (cmd_q == OP_READ) read_q = shift_q;
        cmd_q = OP_NONE;
        phase_q = 2'd0;
        bit_q = 4'd0;
        wait_q = 16'd0;
        finished = 1'b1;
      end
    end
  endtask

  task automatic step_sequencer(input in_t t, output out_t r);
    logic finished;
    logic turned_away;
    finished = 1'b0;
    turned_away = 1'b0;
    if (cmd_q == OP_NONE) begin
      if (t.op >= OP_START && t.op <= OP_NACK) begin
        cmd_q = op_t'(t.op);
        bit_q = 4'd0;
        shift_q = (t.op == OP_WRITE) ? t.data_byte : 8'h00;
        if (t.op == OP_READ && lead_ticks != '0) begin
          phase_q = 2'd2;
          wait_q = lead_ticks;
        end else begin
          enter_segment(2'd0);
        end
      end
    end else if (t.op != OP_NONE) begin
      turned_away = 1'b1;
    end
    r.scl_release = scl_q;
    r.sda_release = sda_q;
    if (cmd_q != OP_NONE) begin
      if (wait_q != 16'd0) wait_q = wait_q - 16'd1;
      if (wait_q == 16'd0) close_segment(t.sda_level, finished);
    end
    r.busy_res = (cmd_q != OP_NONE);
    r.done_res = finished;
    r.read_value = read_q;
    r.ack_error = ack_q;
    r.refused = turned_away;
  endtask

  task automatic send_tick(input in_t t, input logic typed, input out_t want);
    out_t predicted;
    while (idling && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_sequencer(t, predicted);
    expected_pins.push_back(typed ? want : predicted);
  endtask

  // idle ticks until the mirror says the running command is over
  task automatic run_until_idle(input logic sda_fixed, input logic noisy);
    in_t t;
    while (cmd_q != OP_NONE) begin
      t = make_tick(OP_NONE, 8'($urandom), sda_fixed);
      if (noisy) begin
        t.sda_level = 1'($urandom);
        if ($urandom_range(0, 99) < 10) t.op = 4'($urandom_range(1, 15));
      end
      send_tick(t, 1'b0, IDLE_AFTER_RESET);
    end
  endtask

  task automatic write_register(input logic sel, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_idx <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    if (sel == CFG_HALF_PERIOD) half_ticks = val;
    else lead_ticks = val;
  endtask

  // commands mostly land on an idle engine, the rest is noise and refused traffic
  function automatic in_t random_tick();
    in_t t;
    int  roll;
    t.data_byte = 8'($urandom);
    t.sda_level = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (cmd_q == OP_NONE) begin
      if (roll < 84) t.op = 4'($urandom_range(1, 8));
      else if (roll < 92) t.op = OP_NONE;
      else t.op = 4'($urandom_range(9, 15));
    end else begin
      if (roll < 88) t.op = OP_NONE;
      else t.op = 4'($urandom_range(1, 15));
    end
    return t;
  endfunction

  initial begin
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_idx <= CFG_HALF_PERIOD;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_item <= '0;

    half_ticks = HALF_PERIOD_RST;
    lead_ticks = READ_LEAD_RST;
    scl_q = 1'b1;
    sda_q = 1'b1;
    cmd_q = OP_NONE;
    phase_q = 2'd0;
    bit_q = 4'd0;
    shift_q = 8'h00;
    wait_q = 16'd0;
    ack_q = 1'b0;
    read_q = 8'h00;

    // reset register values first
    stim_table.push_back(idle_row(OP_NONE, 1'b0));
    stim_table.push_back(idle_row(4'd9, 1'b1));
    stim_table.push_back(idle_row(4'd15, 1'b0));
    stim_table.push_back(tick_row(OP_START, 8'h00, 1'b1, 1'b1));
    // shortest segments, read with no lead time
    stim_table.push_back(cfg_row(CFG_HALF_PERIOD, 16'd1));
    stim_table.push_back(cfg_row(CFG_READ_LEAD, 16'd0));
    stim_table.push_back(tick_row(OP_WRITE, 8'hFF, 1'b0, 1'b1));
    stim_table.push_back(tick_row(OP_WRITE, 8'h00, 1'b1, 1'b1));
    stim_table.push_back(tick_row(OP_READ, 8'h00, 1'b0, 1'b1));
    stim_table.push_back(tick_row(OP_CHK_ACK, 8'h00, 1'b1, 1'b1));
    stim_table.push_back(tick_row(OP_CHK_ACK, 8'h00, 1'b0, 1'b1));
    stim_table.push_back(tick_row(OP_ACK, 8'h00, 1'b1, 1'b1));
    stim_table.push_back(tick_row(OP_NACK, 8'h00, 1'b0, 1'b1));
    stim_table.push_back(tick_row(OP_RESTART, 8'h00, 1'b1, 1'b1));
    stim_table.push_back(tick_row(OP_STOP, 8'h00, 1'b0, 1'b1));
    // commands while busy, an unknown one among them
    stim_table.push_back(tick_row(OP_WRITE, 8'h3C, 1'b1, 1'b0));
    stim_table.push_back(tick_row(OP_READ, 8'h00, 1'b0, 1'b0));
    stim_table.push_back(tick_row(4'd13, 8'hC3, 1'b1, 1'b1));
    // zero half period behaves as one tick
    stim_table.push_back(cfg_row(CFG_HALF_PERIOD, 16'd0));
    stim_table.push_back(tick_row(OP_WRITE, 8'hA5, 1'b0, 1'b1));
    stim_table.push_back(cfg_row(CFG_READ_LEAD, 16'd20));
    stim_table.push_back(tick_row(OP_READ, 8'h00, 1'b1, 1'b1));
    stim_table.push_back(cfg_row(CFG_HALF_PERIOD, 16'd30));
    stim_table.push_back(cfg_row(CFG_READ_LEAD, 16'd0));
    stim_table.push_back(tick_row(OP_START, 8'h00, 1'b0, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_CFG) begin
        write_register(stim_table[i].cfg_sel, stim_table[i].cfg_val);
      end else begin
        send_tick(stim_table[i].tick, stim_table[i].typed, stim_table[i].want);
        if (stim_table[i].drain) run_until_idle(stim_table[i].tick.sda_level, 1'b0);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_register(CFG_HALF_PERIOD, (p == 0) ? 16'd1 : 16'($urandom_range(0, 4)));
      write_register(CFG_READ_LEAD, (p == 1) ? 16'd0 : 16'($urandom_range(0, 12)));
      idling = (p != 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) begin
          // let the engine drain completely before going on
          in_valid <= 1'b0;
          @(posedge clk);
          while (expected_pins.size() != 0) @(posedge clk);
        end
        send_tick(random_tick(), 1'b0, IDLE_AFTER_RESET);
      end
      run_until_idle(1'b1, 1'b1);
    end
    idling = 1'b1;

    in_valid <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_pins.size() == 0) begin
      $display("i2c_master_bit_engine test passed");
    end else begin
      $display("i2c_master_bit_engine test failed");
    end
    $finish;
  end

  initial begin
    out_t want;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (expected_pins.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected result item: scl=%b sda=%b busy=%b done=%b rd=%h ack=%b ref=%b",
                     out_item.scl_release, out_item.sda_release, out_item.busy_res,
                     out_item.done_res, out_item.read_value, out_item.ack_error,
                     out_item.refused);
        end else begin
          want = expected_pins.pop_front();
          if (out_item.scl_release !== want.scl_release ||
              out_item.sda_release !== want.sda_release ||
              out_item.busy_res !== want.busy_res ||
              out_item.done_res !== want.done_res ||
              out_item.read_value !== want.read_value ||
              out_item.ack_error !== want.ack_error ||
              out_item.refused !== want.refused) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
              $display("mismatch exp: scl=%b sda=%b busy=%b done=%b rd=%h ack=%b ref=%b",
                       want.scl_release, want.sda_release, want.busy_res, want.done_res,
                       want.read_value, want.ack_error, want.refused);
              $display("         got: scl=%b sda=%b busy=%b done=%b rd=%h ack=%b ref=%b",
                       out_item.scl_release, out_item.sda_release, out_item.busy_res,
                       out_item.done_res, out_item.read_value, out_item.ack_error,
                       out_item.refused);
            end
          end
        end
      end
      out_ready <= !rst && (!idling || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

endmodule
